@@ hdl/pip_pkg.sv @@
// Shared types and constants for the point-in-polygon crossing test.
`default_nettype none

package pip_pkg;

  // Item command codes; code 3 is unused and ignored
  localparam int unsigned CMD_W = 2;
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  // Register port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [0:0]  REG_KEEP_MODE = 1'b0;

  // Per-cell control of the vertex ring
  typedef struct packed {
    logic shift;  // take the neighbor's vertex
    logic load;   // take the write vertex
  } cell_ctl_t;

  // Edge unit status toward the sequencer
  typedef struct packed {
    logic busy;    // some edge still in flight
    logic toggle;  // finished edge flips the parity
  } edge_stat_t;

endpackage

`default_nettype wire

@@ hdl/pip_ifs.sv @@
// Item channel interfaces: query/vertex input and inside/keep result.
`default_nettype none

interface pip_in_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic [pip_pkg::CMD_W-1:0]     command;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;

  modport source (output valid, command, x_coord, y_coord, input ready);
  modport sink   (input valid, command, x_coord, y_coord, output ready);
endinterface

interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic keep;

  modport source (output valid, inside_res, keep, input ready);
  modport sink   (input valid, inside_res, keep, output ready);
endinterface

`default_nettype wire

@@ hdl/point_in_polygon_test_top.sv @@
// Top level: even-odd point-in-polygon test over a rotating ring of vertex cells.
//
//  channel  | dir | fields                        | handshake
//  ---------+-----+-------------------------------+---------------------------
//  in_if    | in  | command, x_coord, y_coord     | valid/ready
//  out_if   | out | inside_res, keep              | valid/ready
//  cfg_*    | in  | keep-mode flag at byte addr 0 | APB write, pready tied high
//
// Clear and add-vertex items give no result.
// A query rotates the ring through a full turn, one edge into the edge unit per cycle,
// then drains the six-stage edge pipe before the result is set on out_if.
// rst_n (synchronous, active low) empties the polygon and clears the keep mode.
// Input waits only on a query in progress; a held result stalls the next one in drain.
`default_nettype none

module point_in_polygon_test_top #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned COORD_WIDTH  = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  pip_in_if.sink                             in_if,
  pip_out_if.source                          out_if,
  input  wire                                cfg_psel,
  input  wire                                cfg_penable,
  input  wire                                cfg_pwrite,
  input  wire [pip_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  wire [pip_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [pip_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);
  import pip_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_VERTICES);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;   // stored vertices
  logic [CNT_W-1:0] step_r, step_nxt;     // ring rotations so far
  logic             parity_r, parity_nxt;
  logic             clip_r, clip_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic             out_inside_r, out_inside_nxt;
  logic             out_keep_r, out_keep_nxt;

  logic signed [COORD_WIDTH-1:0] qx_r, qy_r;
  logic signed [COORD_WIDTH-1:0] first_x_r, first_y_r;  // vertex 0 for the closing edge
  logic signed [COORD_WIDTH-1:0] prev_x_r, prev_y_r;    // vertex before the head

  logic  accept;
  cmd_t  cmd;
  logic  add_fire;
  logic  rotate;
  logic  issue_mid, issue_close, issue;
  logic  cfg_wr, cfg_hit;

  logic signed [COORD_WIDTH-1:0] cell_x [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] cell_y [MAX_VERTICES];
  cell_ctl_t                     cell_ctl [MAX_VERTICES];
  edge_stat_t                    edge_st;

  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign cmd         = cmd_t'(in_if.command);
  assign add_fire    = accept && (cmd == CMD_ADD) && (count_r < MAXC);

  // ring turns once fully per query, so cells are back home afterward
  assign rotate      = (state_r == S_RUN) && (step_r < MAXC);
  // edge (v[k], v[k-1]) for 1 <= k < n, then the closing edge (v[0], v[n-1])
  assign issue_mid   = (state_r == S_RUN) && (step_r != '0) && (step_r < count_r);
  assign issue_close = (state_r == S_RUN) && (count_r != '0) && (step_r == count_r);
  assign issue       = issue_mid || issue_close;

  // ---------------- register port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[CFG_ADDR_W-1:2] == REG_KEEP_MODE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign cfg_prdata = cfg_hit ? {{(CFG_DATA_W-1){1'b0}}, clip_r} : '0;

  // ---------------- vertex ring ----------------
  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_ring
    localparam int unsigned NB = (g + 1) % MAX_VERTICES;
    assign cell_ctl[g].shift = rotate;
    assign cell_ctl[g].load  = add_fire && (count_r[IDX_W-1:0] == IDX_W'(g));
    pip_cell #(.COORD_WIDTH(COORD_WIDTH)) u_cell (
      .clk   (clk),
      .ctl   (cell_ctl[g]),
      .nbr_x (cell_x[NB]),
      .nbr_y (cell_y[NB]),
      .wr_x  (in_if.x_coord),
      .wr_y  (in_if.y_coord),
      .x     (cell_x[g]),
      .y     (cell_y[g])
    );
  end

  // ---------------- edge unit ----------------
  pip_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (issue),
    .xi    (issue_close ? first_x_r : cell_x[0]),
    .yi    (issue_close ? first_y_r : cell_y[0]),
    .xj    (prev_x_r),
    .yj    (prev_y_r),
    .qx    (qx_r),
    .qy    (qy_r),
    .stat  (edge_st)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    parity_nxt     = parity_r ^ edge_st.toggle;
    clip_nxt       = cfg_wr ? cfg_pwdata[0] : clip_r;
    out_vld_nxt    = out_vld_r && !out_if.ready;
    out_inside_nxt = out_inside_r;
    out_keep_nxt   = out_keep_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_CLEAR: count_nxt = '0;
            CMD_ADD: begin
              if (count_r < MAXC) count_nxt = CNT_W'(count_r + 1'b1);
            end
            CMD_QUERY: begin
              state_nxt  = S_RUN;
              step_nxt   = '0;
              parity_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        step_nxt = CNT_W'(step_r + 1'b1);
        if (step_r == MAXC) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        // last toggle lands before busy drops
        if (!edge_st.busy && (!out_vld_r || out_if.ready)) begin
          out_vld_nxt    = 1'b1;
          out_inside_nxt = parity_r;
          out_keep_nxt   = (parity_r == clip_r);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      step_r       <= '0;
      parity_r     <= 1'b0;
      clip_r       <= 1'b0;
      out_vld_r    <= 1'b0;
      out_inside_r <= 1'b0;
      out_keep_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      step_r       <= step_nxt;
      parity_r     <= parity_nxt;
      clip_r       <= clip_nxt;
      out_vld_r    <= out_vld_nxt;
      out_inside_r <= out_inside_nxt;
      out_keep_r   <= out_keep_nxt;
    end
  end

  // query point and edge endpoints
  always_ff @(posedge clk) begin
    if (accept && (cmd == CMD_QUERY)) begin
      qx_r <= in_if.x_coord;
      qy_r <= in_if.y_coord;
    end
    if ((state_r == S_RUN) && (step_r == '0)) begin
      first_x_r <= cell_x[0];
      first_y_r <= cell_y[0];
    end
    if (rotate) begin
      prev_x_r <= cell_x[0];
      prev_y_r <= cell_y[0];
    end
  end

  assign out_if.valid      = out_vld_r;
  assign out_if.inside_res = out_inside_r;
  assign out_if.keep       = out_keep_r;

  // ---------------- checks ----------------
  a_run_full_turn : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && state_nxt == S_DRAIN) |-> (step_r == MAXC))
    else $error("ring left before a full turn");

  a_drain_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN && state_nxt == S_IDLE) |-> !edge_st.busy)
    else $error("result taken with edges in flight");

  a_issue_in_run : assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (state_r == S_RUN && step_r <= count_r))
    else $error("edge issued outside the vertex walk");

  a_count_cap : assert property (@(posedge clk) disable iff (!rst_n)
    add_fire |=> (count_r <= MAXC && count_r != '0))
    else $error("vertex count out of range");

endmodule

`default_nettype wire

@@ hdl/pip_cell.sv @@
// One vertex cell of the rotating vertex ring.
`default_nettype none

module pip_cell #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire                           clk,
  input  pip_pkg::cell_ctl_t            ctl,
  input  wire signed [COORD_WIDTH-1:0]  nbr_x,
  input  wire signed [COORD_WIDTH-1:0]  nbr_y,
  input  wire signed [COORD_WIDTH-1:0]  wr_x,
  input  wire signed [COORD_WIDTH-1:0]  wr_y,
  output logic signed [COORD_WIDTH-1:0] x,
  output logic signed [COORD_WIDTH-1:0] y
);
  import pip_pkg::*;

  logic signed [COORD_WIDTH-1:0] x_r;
  logic signed [COORD_WIDTH-1:0] y_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_r <= wr_x;
      y_r <= wr_y;
    end else if (ctl.shift) begin
      x_r <= nbr_x;
      y_r <= nbr_y;
    end
  end

  assign x = x_r;
  assign y = y_r;

endmodule

`default_nettype wire

@@ hdl/pip_edge.sv @@
// Pipelined edge crossing test: one edge per cycle, exact cross-multiplied compare.
`default_nettype none

module pip_edge #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          issue,
  input  wire signed [COORD_WIDTH-1:0] xi,
  input  wire signed [COORD_WIDTH-1:0] yi,
  input  wire signed [COORD_WIDTH-1:0] xj,
  input  wire signed [COORD_WIDTH-1:0] yj,
  input  wire signed [COORD_WIDTH-1:0] qx,
  input  wire signed [COORD_WIDTH-1:0] qy,
  output pip_pkg::edge_stat_t          stat
);
  import pip_pkg::*;

  localparam int unsigned LAT = 6;
  localparam int unsigned DW  = COORD_WIDTH + 1;  // difference width
  localparam int unsigned HW  = (DW + 1) / 2;     // half-word for partial products
  localparam int unsigned PPW = 2 * HW;
  localparam int unsigned QW  = 4 * HW;
  localparam int unsigned PW  = 2 * DW;           // product magnitude
  localparam int unsigned SW  = PW + 1;           // signed product

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
    mag = v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [DW-1:0] sdiff(input logic [COORD_WIDTH-1:0] a,
                                          input logic [COORD_WIDTH-1:0] b);
    sdiff = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
  endfunction

  // control pipe
  logic [LAT-1:0] v_r;
  logic [LAT-2:0] hit_r;
  logic [LAT-2:0] dpos_r;
  logic           tog_r;

  logic hit_in;
  logic dpos_in;
  assign hit_in  = ((yi < qy && yj >= qy) || (yj < qy && yi >= qy)) && (xi <= qx || xj <= qx);
  assign dpos_in = yj > yi;

  // stage 1: differences
  logic [DW-1:0] a1_r, b1_r, a2_r, b2_r;
  // stage 2: magnitudes and product signs
  logic [DW-1:0] ma1_r, mb1_r, ma2_r, mb2_r;
  logic          nl2_r, nr2_r;
  // stage 3: partial products (lo*lo, lo*hi, hi*lo, hi*hi)
  logic [PPW-1:0] ppl_r [4];
  logic [PPW-1:0] ppr_r [4];
  logic           nl3_r, nr3_r;
  // stage 4: product magnitudes
  logic [PW-1:0] pl_r, pr_r;
  logic          nl4_r, nr4_r;
  // stage 5: signed products
  logic [SW-1:0] sl_r, sr_r;

  logic [HW-1:0] a1_lo, a1_hi, b1_lo, b1_hi, a2_lo, a2_hi, b2_lo, b2_hi;
  assign a1_lo = ma1_r[HW-1:0];
  assign a1_hi = HW'(ma1_r[DW-1:HW]);
  assign b1_lo = mb1_r[HW-1:0];
  assign b1_hi = HW'(mb1_r[DW-1:HW]);
  assign a2_lo = ma2_r[HW-1:0];
  assign a2_hi = HW'(ma2_r[DW-1:HW]);
  assign b2_lo = mb2_r[HW-1:0];
  assign b2_hi = HW'(mb2_r[DW-1:HW]);

  logic [QW-1:0] suml, sumr;
  assign suml = QW'(ppl_r[0]) + ((QW'(ppl_r[1]) + QW'(ppl_r[2])) << HW)
              + (QW'(ppl_r[3]) << (2 * HW));
  assign sumr = QW'(ppr_r[0]) + ((QW'(ppr_r[1]) + QW'(ppr_r[2])) << HW)
              + (QW'(ppr_r[3]) << (2 * HW));

  logic left;
  assign left = dpos_r[LAT-2] ? ($signed(sl_r) < $signed(sr_r))
                              : ($signed(sr_r) < $signed(sl_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      tog_r <= 1'b0;
    end else begin
      v_r   <= {v_r[LAT-2:0], issue};
      tog_r <= v_r[LAT-2] && hit_r[LAT-2] && left;
    end
  end

  always_ff @(posedge clk) begin
    hit_r  <= {hit_r[LAT-3:0], hit_in};
    dpos_r <= {dpos_r[LAT-3:0], dpos_in};
    // lhs = (qy-yi)*(xj-xi), rhs = (qx-xi)*(yj-yi)
    a1_r <= sdiff(qy, yi);
    b1_r <= sdiff(xj, xi);
    a2_r <= sdiff(qx, xi);
    b2_r <= sdiff(yj, yi);
    ma1_r <= mag(a1_r);
    mb1_r <= mag(b1_r);
    ma2_r <= mag(a2_r);
    mb2_r <= mag(b2_r);
    nl2_r <= a1_r[DW-1] ^ b1_r[DW-1];
    nr2_r <= a2_r[DW-1] ^ b2_r[DW-1];
    ppl_r[0] <= PPW'(a1_lo) * PPW'(b1_lo);
    ppl_r[1] <= PPW'(a1_lo) * PPW'(b1_hi);
    ppl_r[2] <= PPW'(a1_hi) * PPW'(b1_lo);
    ppl_r[3] <= PPW'(a1_hi) * PPW'(b1_hi);
    ppr_r[0] <= PPW'(a2_lo) * PPW'(b2_lo);
    ppr_r[1] <= PPW'(a2_lo) * PPW'(b2_hi);
    ppr_r[2] <= PPW'(a2_hi) * PPW'(b2_lo);
    ppr_r[3] <= PPW'(a2_hi) * PPW'(b2_hi);
    nl3_r <= nl2_r;
    nr3_r <= nr2_r;
    pl_r  <= suml[PW-1:0];
    pr_r  <= sumr[PW-1:0];
    nl4_r <= nl3_r;
    nr4_r <= nr3_r;
    sl_r  <= nl4_r ? (SW'(0) - {1'b0, pl_r}) : {1'b0, pl_r};
    sr_r  <= nr4_r ? (SW'(0) - {1'b0, pr_r}) : {1'b0, pr_r};
  end

  assign stat.busy   = |v_r;
  assign stat.toggle = tog_r;

endmodule

`default_nettype wire
